>>> design/sia_pkg.sv
package sia_pkg;

    // default array depth
    localparam int CAPACITY_DEF = 32;

    // field widths
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 6;
    localparam int COUNT_W  = 6;
    localparam int ACTION_W = 2;
    localparam int STATUS_W = 2;

    // packed stream widths
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 40;

    // request actions
    typedef enum logic [ACTION_W-1:0] {
        ACT_INSERT = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_SETCNT = 2'd2,
        ACT_READ   = 2'd3
    } action_t;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    // controller states
    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } state_t;

    // controller to datapath commands
    typedef struct packed {
        logic capture;
        logic execute;
    } sia_cmd_t;

endpackage

>>> design/sia_ctrl.sv
module sia_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    output sia_pkg::sia_cmd_t cmd
);

    sia_pkg::state_t state_reg;
    sia_pkg::state_t state_next;
    logic            out_valid_reg;
    logic            out_valid_next;
    logic            out_free;

    // output register can take a new result
    assign out_free = !out_valid_reg || m_tready;

    // state and result-valid registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sia_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !m_tready;
        s_tready       = 1'b0;
        cmd.capture    = 1'b0;
        cmd.execute    = 1'b0;
        case (state_reg)
            sia_pkg::S_IDLE:
            begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
                if (s_tvalid)
                begin
                    state_next = sia_pkg::S_EXEC;
                end
            end
            sia_pkg::S_EXEC:
            begin
                if (out_free)
                begin
                    cmd.execute    = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = sia_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = sia_pkg::S_IDLE;
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;

    // a pending result is never dropped
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_tready) |=> out_valid_reg)
        else $error("pending result lost");

    // a request is executed only while in the execute state
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.execute |-> (state_reg == sia_pkg::S_EXEC) && out_free)
        else $error("execute outside execute state");

endmodule

>>> design/sia_datapath.sv
module sia_datapath
#(
    parameter int CAPACITY = sia_pkg::CAPACITY_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  sia_pkg::sia_cmd_t                   cmd,
    input  logic [sia_pkg::ACTION_W-1:0]        action,
    input  logic signed [sia_pkg::VALUE_W-1:0]  value,
    input  logic [sia_pkg::POS_W-1:0]           position,
    output logic signed [sia_pkg::VALUE_W-1:0]  read_value,
    output logic [sia_pkg::COUNT_W-1:0]         count,
    output logic [sia_pkg::STATUS_W-1:0]        status
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);

    // captured request
    logic [sia_pkg::ACTION_W-1:0]       act_reg;
    logic signed [sia_pkg::VALUE_W-1:0] val_reg;
    logic [sia_pkg::POS_W-1:0]          pos_reg;

    // array cells and entry count
    logic signed [sia_pkg::VALUE_W-1:0] cell_reg [CAPACITY];
    logic signed [sia_pkg::VALUE_W-1:0] cell_next [CAPACITY];
    logic [CNT_W-1:0]                   cnt_reg;
    logic [CNT_W-1:0]                   cnt_next;

    // result registers
    logic signed [sia_pkg::VALUE_W-1:0] rd_reg;
    logic signed [sia_pkg::VALUE_W-1:0] rd_next;
    logic [sia_pkg::STATUS_W-1:0]       st_reg;
    logic [sia_pkg::STATUS_W-1:0]       st_next;

    logic [CAPACITY-1:0] gt;
    logic [CAPACITY-1:0] above;
    logic                do_insert;
    logic [31:0]         pos_ext;
    logic [31:0]         cnt_ext;
    logic [IDX_W-1:0]    rd_idx;

    assign pos_ext = 32'(pos_reg);
    assign cnt_ext = 32'(cnt_reg);
    assign rd_idx  = IDX_W'(pos_ext);

    // request capture
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            act_reg <= action;
            val_reg <= value;
            pos_reg <= position;
        end
    end

    // per-cell compare: new value above a valid entry
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            gt[i] = (val_reg > cell_reg[i]) && (32'(i) < cnt_ext);
        end
    end

    // any compare hit at or above each cell
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            above[i] = |(gt & ({CAPACITY{1'b1}} << i));
        end
    end

    assign do_insert = (act_reg == sia_pkg::ACT_INSERT) && (cnt_ext < 32'(CAPACITY));

    // cell update: keep, take new value, or take lower neighbor
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            cell_next[i] = cell_reg[i];
            if (do_insert)
            begin
                if (i == 0)
                begin
                    if (!above[0])
                    begin
                        cell_next[i] = val_reg;
                    end
                end
                else if (32'(i) <= cnt_ext)
                begin
                    if (!above[i-1])
                    begin
                        cell_next[i] = cell_reg[i-1];
                    end
                    else if (!above[i])
                    begin
                        cell_next[i] = val_reg;
                    end
                end
            end
        end
    end

    // count, status and read value
    always_comb
    begin
        cnt_next = cnt_reg;
        st_next  = sia_pkg::ST_OK;
        rd_next  = '0;
        case (act_reg)
            sia_pkg::ACT_INSERT:
            begin
                if (do_insert)
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
                else
                begin
                    st_next = sia_pkg::ST_FULL;
                end
            end
            sia_pkg::ACT_REMOVE:
            begin
                if (cnt_reg == '0)
                begin
                    st_next = sia_pkg::ST_EMPTY;
                end
                else
                begin
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            sia_pkg::ACT_SETCNT:
            begin
                if (pos_ext > 32'(CAPACITY))
                begin
                    st_next = sia_pkg::ST_RANGE;
                end
                else
                begin
                    cnt_next = CNT_W'(pos_ext);
                end
            end
            sia_pkg::ACT_READ:
            begin
                if (pos_ext >= cnt_ext || pos_ext >= 32'(CAPACITY))
                begin
                    st_next = sia_pkg::ST_RANGE;
                end
                else
                begin
                    rd_next = cell_reg[rd_idx];
                end
            end
            default:
            begin
                st_next = sia_pkg::ST_OK;
            end
        endcase
    end

    // cells and count, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            for (int i = 0; i < CAPACITY; i++)
            begin
                cell_reg[i] <= '0;
            end
        end
        else if (cmd.execute)
        begin
            cnt_reg <= cnt_next;
            for (int i = 0; i < CAPACITY; i++)
            begin
                cell_reg[i] <= cell_next[i];
            end
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.execute)
        begin
            rd_reg <= rd_next;
            st_reg <= st_next;
        end
    end

    assign read_value = rd_reg;
    assign count      = sia_pkg::COUNT_W'(cnt_reg);
    assign status     = st_reg;

    // count stays within capacity
    assert property (@(posedge clk) disable iff (!rst_n)
        32'(cnt_reg) <= 32'(CAPACITY))
        else $error("count above capacity");

    // a successful insert grows the count by one
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.execute && do_insert) |=> cnt_reg == $past(cnt_reg) + CNT_W'(1))
        else $error("insert did not grow count");

    // only reads return data
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.execute && act_reg != sia_pkg::ACT_READ) |=> rd_reg == '0)
        else $error("nonzero read value on non-read");

endmodule

>>> design/sorted_insert_array.sv
// sorted_insert_array: bounded array of signed 32-bit values kept in
// ascending order, driven by one request per input transfer.
// input stream (s_*): s_tuser carries the action (insert, remove last,
// set count, read); s_tdata carries the value and the position.
// output stream (m_*): one result per request, with the read value, the
// entry count after the request, and a status code on m_tuser.
// a request is captured in the idle state and executed in the execute state
// once the output register is free; m_tvalid is registered and rises after
// execution. a new request is taken only after the previous one has executed,
// as set by the capture/execute sequence of the controller; the insert itself
// is combinational through a row of compare-and-shift cells.
// the output register lets a new request be taken while the previous result
// waits; a stalled receiver holds the next request in its execute cycle
// until the output register frees, so no result is lost or repeated.
// reset clears every cell, the entry count, the result valid flag and the
// controller state at once; the block accepts requests as soon as reset is
// released.
module sorted_insert_array
#(
    parameter int CAPACITY = sia_pkg::CAPACITY_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [sia_pkg::S_TDATA_W-1:0] s_tdata,  // value[31:0], position[37:32], zero pad
    input  logic [sia_pkg::ACTION_W-1:0]  s_tuser,  // action[1:0]
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [sia_pkg::M_TDATA_W-1:0] m_tdata,  // read_value[31:0], count[37:32], zero pad
    output logic [sia_pkg::STATUS_W-1:0]  m_tuser   // status[1:0]
);

    sia_pkg::sia_cmd_t                  cmd;
    logic signed [sia_pkg::VALUE_W-1:0] read_value;
    logic [sia_pkg::COUNT_W-1:0]        count;
    logic [sia_pkg::STATUS_W-1:0]       status;

    // sequencing
    sia_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    // array cells and result
    sia_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .action     (s_tuser),
        .value      (s_tdata[31:0]),
        .position   (s_tdata[37:32]),
        .read_value (read_value),
        .count      (count),
        .status     (status)
    );

    // output packing
    assign m_tdata = {2'b00, count, read_value};
    assign m_tuser = status;

endmodule
